// ===== hw/rtl/case_insensitive_substring_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the substring search block.
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CISS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CISS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ciss_pkg.sv =====
// ----------------------------------------------------------------------------
// ciss_pkg
// Types, constants and helpers for the case-insensitive substring search.
// ----------------------------------------------------------------------------
package ciss_pkg;

    localparam int MAX_PATTERN  = 8;
    localparam int CHAR_W       = 8;
    localparam int PAT_W        = 64;
    localparam int LEN_W        = 4;
    localparam int PAT_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W        = 17;
    localparam int OFFSET_W     = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 64;

    localparam logic [POS_W-1:0]   POS_MAX    = {POS_W{1'b1}};
    localparam logic [CHAR_W-1:0]  FOLD_BELOW = 8'd96;
    localparam logic [CHAR_W-1:0]  FOLD_ABOVE = 8'd123;
    localparam logic [CHAR_W-1:0]  FOLD_MASK  = 8'hdf;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic char_t fold_char(input char_t c);
        if (c > FOLD_BELOW && c < FOLD_ABOVE)
        begin
            return c & FOLD_MASK;
        end
        return c;
    endfunction

    function automatic char_t pattern_char(input logic [PAT_W-1:0] pat,
                                           input logic [PAT_IDX_W-1:0] idx);
        return pat[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== hw/rtl/ciss_if.sv =====
// ----------------------------------------------------------------------------
// ciss interfaces
// Valid/ready channels for text words, result words and register writes.
// ----------------------------------------------------------------------------
interface ciss_text_if
    import ciss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ciss_result_if
    import ciss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface ciss_cfg_if
    import ciss_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ciss_cell.sv =====
// ----------------------------------------------------------------------------
// ciss_cell
// One window slot: holds a folded text byte, compares the byte moving in
// against its pattern character and passes the old byte to the next slot.
// ----------------------------------------------------------------------------
module ciss_cell
    import ciss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       active,
    input  char_t      want,
    input  char_t      char_in,
    output char_t      char_out,
    output logic       hit
);

    char_t char_reg;
    char_t char_next;

    always_comb
    begin
        char_next = char_reg;
        if (ctrl.clear)
        begin
            char_next = '0;
        end
        else if (ctrl.shift)
        begin
            char_next = char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
        end
    end

    assign char_out = char_reg;
    assign hit      = !active || (char_in == want);

endmodule

// ===== hw/rtl/case_insensitive_substring_search.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_search
// Streams text words through a row of compare cells and reports the start
// offset of the first case-folded match of the pattern, or not found.
//
//   channel  dir  word fields                    handshake
//   text     in   text_byte, end_of_text         valid/ready
//   result   out  found, match_offset            valid/ready
//   cfg      in   index, data                    valid/ready, always ready
//
// One text word per cycle while text.ready is high; the cell row compares the
// whole window in the cycle a word is taken, and the result register loads at
// that same edge. A result appears in the cycle after the word that causes it.
// text.ready drops only while a result word waits and result.ready is low.
// Reset clears pattern, window, position and the match flag; no clearing pass.
// ----------------------------------------------------------------------------
`include "case_insensitive_substring_search_macros.svh"

module case_insensitive_substring_search
    import ciss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ciss_text_if.sink            text,
    ciss_result_if.source        result,
    ciss_cfg_if.sink             cfg
);

    logic [PAT_W-1:0]    pattern_bytes_reg;
    logic [LEN_W-1:0]    pattern_length_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                reported_reg;
    logic                reported_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                res_found_reg;
    logic                res_found_next;
    logic [OFFSET_W-1:0] res_offset_reg;
    logic [OFFSET_W-1:0] res_offset_next;

    logic                take;
    logic                last;
    cell_ctrl_t          cell_ctrl;
    char_t               win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;
    logic                len_ok;
    logic [POS_W:0]      pos_p1;
    logic [POS_W:0]      start;
    logic                enough;
    logic                start_ok;
    logic                match;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg.data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[LEN_W-1:0];
                default:            pattern_bytes_reg  <= pattern_bytes_reg;
            endcase
        end
    end

    assign text.ready = !res_valid_reg || result.ready;
    assign take       = text.valid && text.ready;
    assign last       = text.end_of_text;

    assign cell_ctrl.shift = take && !reported_reg;
    assign cell_ctrl.clear = take && last;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [LEN_W-1:0] sel;
            logic             active;
            char_t            char_in;

            assign sel    = pattern_length_reg - LEN_W'(k) - LEN_W'(1);
            assign active = pattern_length_reg > LEN_W'(k);

            if (k == 0)
            begin : g_head
                assign char_in = fold_char(text.text_byte);
            end
            else
            begin : g_body
                assign char_in = win[k-1];
            end

            ciss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .active   (active),
                .want     (pattern_char(pattern_bytes_reg, sel[PAT_IDX_W-1:0])),
                .char_in  (char_in),
                .char_out (win[k]),
                .hit      (hits[k])
            );
        end
    endgenerate

    assign len_ok   = (pattern_length_reg != '0)
                   && (pattern_length_reg <= LEN_W'(MAX_PATTERN));
    assign pos_p1   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign enough   = pos_p1 >= (POS_W+1)'(pattern_length_reg);
    assign start    = pos_p1 - (POS_W+1)'(pattern_length_reg);
    assign start_ok = (start[POS_W:OFFSET_W] == '0);
    assign match    = !reported_reg && len_ok && enough && start_ok && (&hits);

    always_comb
    begin
        pos_next        = pos_reg;
        reported_next   = reported_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_found_next  = res_found_reg;
        res_offset_next = res_offset_reg;
        if (take)
        begin
            if (match)
            begin
                res_valid_next  = 1'b1;
                res_found_next  = 1'b1;
                res_offset_next = start[OFFSET_W-1:0];
            end
            else if (last && !reported_reg)
            begin
                res_valid_next  = 1'b1;
                res_found_next  = 1'b0;
                res_offset_next = '0;
            end

            if (last)
            begin
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else if (!reported_reg)
            begin
                reported_next = match;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_p1[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            reported_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            reported_reg  <= reported_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg  <= res_found_next;
        res_offset_reg <= res_offset_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.found        = res_found_reg;
    assign result.match_offset = res_offset_reg;

    `CISS_ASSERT_NEXT(a_end_clears, clk, rst_n, take && last, !reported_reg && (pos_reg == '0), "end of text did not clear string state")
    `CISS_ASSERT_NEXT(a_hold_after_match, clk, rst_n, take && reported_reg && !last, $stable(pos_reg) && reported_reg, "position moved after match")
    `CISS_ASSERT_SAME(a_match_reported, clk, rst_n, $rose(reported_reg), result.valid && result.found, "match flag set without found word")

endmodule
